### rtl/lcdns_pkg.sv
// Shared types, constants and sequence tables for the character LCD nibble sequencer.
`default_nettype none
package lcdns_pkg;

  // Request types on the input channel
  localparam logic [2:0] ReqInit  = 3'd0;
  localparam logic [2:0] ReqCmd   = 3'd1;
  localparam logic [2:0] ReqData  = 3'd2;
  localparam logic [2:0] ReqCur   = 3'd3;
  localparam logic [2:0] ReqClear = 3'd4;
  localparam logic [2:0] ReqHome  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] RegFunctionSet = 3'd0;
  localparam logic [2:0] RegDisplayOn   = 3'd1;
  localparam logic [2:0] RegClear       = 3'd2;
  localparam logic [2:0] RegEntryMode   = 3'd3;
  localparam logic [2:0] RegHome        = 3'd4;
  localparam logic [2:0] RegEnableHigh  = 3'd5;
  localparam logic [2:0] RegEnableLow   = 3'd6;

  // Cursor address bases
  localparam logic [7:0] CurRow1Base = 8'h80;
  localparam logic [7:0] CurRow2Base = 8'hC0;

  // Init nibbles
  localparam logic [3:0] NibWake  = 4'h3;
  localparam logic [3:0] NibFour  = 4'h2;

  // Fixed waits in microseconds
  localparam logic [15:0] WaitPowerupUs = 16'd40000;
  localparam logic [15:0] WaitSecondUs  = 16'd5000;
  localparam logic [15:0] WaitThirdUs   = 16'd150;
  localparam logic [15:0] WaitClearUs   = 16'd2000;

  typedef enum logic [1:0] {
    SegWait = 2'd0,
    SegNib  = 2'd1,
    SegByte = 2'd2
  } seg_kind_e;

  typedef enum logic [1:0] {
    WaitPowerup = 2'd0,
    WaitSecond  = 2'd1,
    WaitThird   = 2'd2,
    WaitClear   = 2'd3
  } wait_e;

  // Front job classes
  typedef enum logic [1:0] {
    JobInit    = 2'd0,
    JobByte    = 2'd1,
    JobCmdWait = 2'd2
  } job_e;

  // One queued segment: a wait, a single nibble or a whole byte
  typedef struct packed {
    seg_kind_e  kind;
    logic       rs;
    logic [7:0] value;
    wait_e      wait_sel;
    logic       last;
  } seg_t;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_on;
    logic [7:0] clear;
    logic [7:0] entry_mode;
    logic [7:0] home;
  } codes_t;

  typedef struct packed {
    logic [9:0] en_high;
    logic [9:0] en_low;
  } timing_t;

  function automatic logic [15:0] wait_hold(input wait_e sel);
    logic [15:0] h;
    unique case (sel)
      WaitPowerup: h = WaitPowerupUs;
      WaitSecond:  h = WaitSecondUs;
      WaitThird:   h = WaitThirdUs;
      WaitClear:   h = WaitClearUs;
      default:     h = WaitClearUs;
    endcase
    return h;
  endfunction

  function automatic seg_t mk_seg(input seg_kind_e kind, input logic rs,
                                  input logic [7:0] value, input wait_e sel,
                                  input logic last);
    seg_t s;
    s.kind     = kind;
    s.rs       = rs;
    s.value    = value;
    s.wait_sel = sel;
    s.last     = last;
    return s;
  endfunction

  // Segment number step of a job
  function automatic seg_t seg_for(input job_e job, input logic [3:0] step,
                                   input logic rs, input logic [7:0] value,
                                   input codes_t codes);
    seg_t s;
    s = mk_seg(SegByte, rs, value, WaitClear, 1'b1);
    unique case (job)
      JobByte: s = mk_seg(SegByte, rs, value, WaitClear, 1'b1);
      JobCmdWait: begin
        if (step == 4'd0) s = mk_seg(SegByte, 1'b0, value, WaitClear, 1'b0);
        else s = mk_seg(SegWait, 1'b0, {4'h0, value[3:0]}, WaitClear, 1'b1);
      end
      JobInit: begin
        unique case (step)
          4'd0:  s = mk_seg(SegWait, 1'b0, 8'h00, WaitPowerup, 1'b0);
          4'd1:  s = mk_seg(SegNib, 1'b0, {4'h0, NibWake}, WaitClear, 1'b0);
          4'd2:  s = mk_seg(SegWait, 1'b0, {4'h0, NibWake}, WaitSecond, 1'b0);
          4'd3:  s = mk_seg(SegNib, 1'b0, {4'h0, NibWake}, WaitClear, 1'b0);
          4'd4:  s = mk_seg(SegWait, 1'b0, {4'h0, NibWake}, WaitThird, 1'b0);
          4'd5:  s = mk_seg(SegNib, 1'b0, {4'h0, NibWake}, WaitClear, 1'b0);
          4'd6:  s = mk_seg(SegNib, 1'b0, {4'h0, NibFour}, WaitClear, 1'b0);
          4'd7:  s = mk_seg(SegByte, 1'b0, codes.function_set, WaitClear, 1'b0);
          4'd8:  s = mk_seg(SegByte, 1'b0, codes.display_on, WaitClear, 1'b0);
          4'd9:  s = mk_seg(SegByte, 1'b0, codes.clear, WaitClear, 1'b0);
          4'd10: s = mk_seg(SegWait, 1'b0, {4'h0, codes.clear[3:0]}, WaitClear, 1'b0);
          default: s = mk_seg(SegByte, 1'b0, codes.entry_mode, WaitClear, 1'b1);
        endcase
      end
      default: s = mk_seg(SegByte, rs, value, WaitClear, 1'b1);
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/lcdns_front.sv
// Request front end: accepts requests, classifies them and issues segments.
`default_nettype none
module lcdns_front
  import lcdns_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] req_type_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic [1:0] row_i,
  input  wire logic [6:0] column_i,
  input  wire codes_t     codes_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output seg_t            q_seg_o
);

  logic       busy_q, busy_d;
  job_e       job_q, job_d;
  logic       rs_q, rs_d;
  logic [7:0] value_q, value_d;
  logic [3:0] step_q, step_d;
  logic       accept;
  logic       start;
  logic [7:0] col_m1;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign col_m1     = {1'b0, column_i} - 8'd1;

  assign q_push_o = busy_q && !q_full_i;
  assign q_seg_o  = seg_for(job_q, step_q, rs_q, value_q, codes_i);

  always_comb begin
    start   = 1'b0;
    job_d   = job_q;
    rs_d    = rs_q;
    value_d = value_q;
    unique case (req_type_i)
      ReqInit:  begin start = 1'b1; job_d = JobInit; rs_d = 1'b0; end
      ReqCmd:   begin start = 1'b1; job_d = JobByte; rs_d = 1'b0; value_d = byte_value_i; end
      ReqData:  begin start = 1'b1; job_d = JobByte; rs_d = 1'b1; value_d = byte_value_i; end
      ReqCur: begin
        job_d = JobByte;
        rs_d  = 1'b0;
        if (row_i == 2'd1) begin
          start   = 1'b1;
          value_d = col_m1 | CurRow1Base;
        end else if (row_i == 2'd2) begin
          start   = 1'b1;
          value_d = col_m1 | CurRow2Base;
        end
      end
      ReqClear: begin start = 1'b1; job_d = JobCmdWait; rs_d = 1'b0; value_d = codes_i.clear; end
      ReqHome:  begin start = 1'b1; job_d = JobCmdWait; rs_d = 1'b0; value_d = codes_i.home; end
      default:  start = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (accept) begin
      busy_d = start;
      step_d = 4'd0;
    end else if (q_push_o) begin
      if (q_seg_o.last) busy_d = 1'b0;
      else step_d = step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Request payload holds for the whole job
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q   <= job_d;
      rs_q    <= rs_d;
      value_q <= value_d;
    end
  end

endmodule
`default_nettype wire

### rtl/lcdns_queue.sv
// Short segment queue between the front end and the event sequencer.
`default_nettype none
module lcdns_queue
  import lcdns_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire seg_t seg_i,
  output logic      full_o,
  input  wire logic pop_i,
  output seg_t      seg_o,
  output logic      valid_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  seg_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign seg_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= seg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

### rtl/lcdns_back.sv
// Event sequencer: expands segments into timed pin events behind an output register.
`default_nettype none
module lcdns_back
  import lcdns_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire timing_t     timing_i,
  input  wire logic        seg_valid_i,
  input  wire seg_t        seg_i,
  output logic             seg_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             reg_select_o,
  output logic             read_write_o,
  output logic             enable_o,
  output logic [3:0]       data_nibble_o,
  output logic [15:0]      hold_us_o,
  output logic             last_o
);

  seg_t        cur_q;
  logic        cur_valid_q;
  logic [1:0]  idx_q;
  logic        out_valid_q;
  logic [1:0]  idx_final;
  logic        adv;
  logic        fin;
  logic        ev_en;
  logic [3:0]  ev_nib;
  logic [15:0] ev_hold;

  always_comb begin
    unique case (cur_q.kind)
      SegWait: idx_final = 2'd0;
      SegNib:  idx_final = 2'd1;
      SegByte: idx_final = 2'd3;
      default: idx_final = 2'd0;
    endcase
  end

  assign adv       = cur_valid_q && (!out_valid_q || out_ready_i);
  assign fin       = adv && (idx_q == idx_final);
  assign seg_pop_o = seg_valid_i && (!cur_valid_q || fin);

  // High nibble first, EN high then low for each nibble
  assign ev_en   = (cur_q.kind != SegWait) && !idx_q[0];
  assign ev_nib  = (cur_q.kind == SegByte && !idx_q[1]) ? cur_q.value[7:4]
                                                         : cur_q.value[3:0];
  assign ev_hold = (cur_q.kind == SegWait) ? wait_hold(cur_q.wait_sel)
                 : idx_q[0] ? {6'd0, timing_i.en_low} : {6'd0, timing_i.en_high};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (seg_pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (fin) begin
        cur_valid_q <= 1'b0;
      end else if (adv) begin
        idx_q <= idx_q + 2'd1;
      end
      if (adv) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_pop_o) cur_q <= seg_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      reg_select_o  <= cur_q.rs;
      enable_o      <= ev_en;
      data_nibble_o <= ev_nib;
      hold_us_o     <= ev_hold;
      last_o        <= cur_q.last && (idx_q == idx_final);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_write_o = 1'b0;

  a_wait_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_q.kind == SegWait) |-> (idx_q == 2'd0))
    else $error("wait segment past its only event");

  a_nib_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_q.kind == SegNib) |-> !idx_q[1])
    else $error("nibble segment past its second event");

endmodule
`default_nettype wire

### rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer: config registers, front, queue, back.
// A request passes the job registers, queue, current segment register and output register.
// One pin event per cycle if out_ready_i is high; a byte request gives 4 events, clear and
// home 5, init 28, set cursor with another row and unused types none.
// A new request is taken once the front end has queued the last segment of the previous one.
// Reset is asynchronous, active low: registers return to their default codes and timings.
`default_nettype none
module char_lcd_nibble_sequencer
  import lcdns_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [9:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [1:0]  row_i,
  input  wire logic [6:0]  column_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             reg_select_o,
  output logic             read_write_o,
  output logic             enable_o,
  output logic [3:0]       data_nibble_o,
  output logic [15:0]      hold_us_o,
  output logic             last_o
);

  codes_t  codes_q;
  timing_t timing_q;
  logic    q_full;
  logic    q_push;
  seg_t    q_seg_in;
  logic    q_pop;
  seg_t    q_seg_out;
  logic    q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.function_set <= 8'd40;
      codes_q.display_on   <= 8'd14;
      codes_q.clear        <= 8'd1;
      codes_q.entry_mode   <= 8'd6;
      codes_q.home         <= 8'd2;
      timing_q.en_high     <= 10'd10;
      timing_q.en_low      <= 10'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegFunctionSet: codes_q.function_set <= cfg_data_i[7:0];
        RegDisplayOn:   codes_q.display_on   <= cfg_data_i[7:0];
        RegClear:       codes_q.clear        <= cfg_data_i[7:0];
        RegEntryMode:   codes_q.entry_mode   <= cfg_data_i[7:0];
        RegHome:        codes_q.home         <= cfg_data_i[7:0];
        RegEnableHigh:  timing_q.en_high     <= cfg_data_i;
        RegEnableLow:   timing_q.en_low      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lcdns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .codes_i      (codes_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_seg_o      (q_seg_in)
  );

  lcdns_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .seg_i   (q_seg_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .seg_o   (q_seg_out),
    .valid_o (q_valid)
  );

  lcdns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timing_i      (timing_q),
    .seg_valid_i   (q_valid),
    .seg_i         (q_seg_out),
    .seg_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reg_select_o  (reg_select_o),
    .read_write_o  (read_write_o),
    .enable_o      (enable_o),
    .data_nibble_o (data_nibble_o),
    .hold_us_o     (hold_us_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

### tb/sv/char_lcd_nibble_sequencer_tb.sv
// Self-checking testbench for the character LCD nibble sequencer.
`timescale 1ns / 100ps
module char_lcd_nibble_sequencer_tb
  import lcdns_pkg::*;
();

  localparam logic [2:0] ReqSpare6 = 3'd6;
  localparam logic [2:0] ReqSpare7 = 3'd7;
  localparam logic [2:0] RegSpare  = 3'd7;
  localparam logic [1:0] RowFirst  = 2'd1;
  localparam logic [1:0] RowSecond = 2'd2;
  localparam int SettleCycles = 10;
  localparam int PhaseItems   = 23;
  localparam longint LimitNs  = 3_000_000;

  typedef struct packed {
    logic        rs;
    logic        rw;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } pin_evt_t;

  // Predicts pin events per request and checks them in order.
  class lcd_scoreboard;
    codes_t   codes;
    timing_t  timing;
    pin_evt_t pin_q[$];
    int       errors;

    function new();
      codes.function_set = 8'd40;
      codes.display_on   = 8'd14;
      codes.clear        = 8'd1;
      codes.entry_mode   = 8'd6;
      codes.home         = 8'd2;
      timing.en_high     = 10'd10;
      timing.en_low      = 10'd100;
      errors             = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [9:0] data);
      case (idx)
        RegFunctionSet: codes.function_set = data[7:0];
        RegDisplayOn:   codes.display_on   = data[7:0];
        RegClear:       codes.clear        = data[7:0];
        RegEntryMode:   codes.entry_mode   = data[7:0];
        RegHome:        codes.home         = data[7:0];
        RegEnableHigh:  timing.en_high     = data;
        RegEnableLow:   timing.en_low      = data;
        default: ;
      endcase
    endfunction

    function void push_pins(logic rs, logic en, logic [3:0] nib, logic [15:0] hold);
      pin_evt_t e;
      e.rs   = rs;
      e.rw   = 1'b0;
      e.en   = en;
      e.nib  = nib;
      e.hold = hold;
      e.last = 1'b0;
      pin_q.push_back(e);
    endfunction

    function void push_nibble(logic rs, logic [3:0] nib);
      push_pins(rs, 1'b1, nib, {6'd0, timing.en_high});
      push_pins(rs, 1'b0, nib, {6'd0, timing.en_low});
    endfunction

    function void push_byte(logic rs, logic [7:0] b);
      push_nibble(rs, b[7:4]);
      push_nibble(rs, b[3:0]);
    endfunction

    function void note_request(logic [2:0] req, logic [7:0] b, logic [1:0] row,
                               logic [6:0] column);
      int start;
      logic [7:0] addr;
      start = pin_q.size();
      addr  = {1'b0, column} - 8'd1;  // column zero wraps to 0xFF
      case (req)
        ReqInit: begin
          push_pins(1'b0, 1'b0, 4'h0, WaitPowerupUs);
          push_nibble(1'b0, NibWake);
          push_pins(1'b0, 1'b0, NibWake, WaitSecondUs);
          push_nibble(1'b0, NibWake);
          push_pins(1'b0, 1'b0, NibWake, WaitThirdUs);
          push_nibble(1'b0, NibWake);
          push_nibble(1'b0, NibFour);
          push_byte(1'b0, codes.function_set);
          push_byte(1'b0, codes.display_on);
          push_byte(1'b0, codes.clear);
          push_pins(1'b0, 1'b0, codes.clear[3:0], WaitClearUs);
          push_byte(1'b0, codes.entry_mode);
        end
        ReqCmd:  push_byte(1'b0, b);
        ReqData: push_byte(1'b1, b);
        ReqCur: begin
          if (row == RowFirst) push_byte(1'b0, addr | CurRow1Base);
          else if (row == RowSecond) push_byte(1'b0, addr | CurRow2Base);
        end
        ReqClear: begin
          push_byte(1'b0, codes.clear);
          push_pins(1'b0, 1'b0, codes.clear[3:0], WaitClearUs);
        end
        ReqHome: begin
          push_byte(1'b0, codes.home);
          push_pins(1'b0, 1'b0, codes.home[3:0], WaitClearUs);
        end
        default: ;
      endcase
      if (pin_q.size() > start) pin_q[pin_q.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_event(pin_evt_t got);
      pin_evt_t want;
      if (pin_q.size() == 0) begin
        $display("%0t: pin event with nothing expected, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pin_q.pop_front();
      compare_field("reg_select", want.rs, got.rs);
      compare_field("read_write", want.rw, got.rw);
      compare_field("enable", want.en, got.en);
      compare_field("data_nibble", want.nib, got.nib);
      compare_field("hold_us", want.hold, got.hold);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return pin_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [9:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  req_type_i;
  logic [7:0]  byte_value_i;
  logic [1:0]  row_i;
  logic [6:0]  column_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        reg_select_o;
  logic        read_write_o;
  logic        enable_o;
  logic [3:0]  data_nibble_o;
  logic [15:0] hold_us_o;
  logic        last_o;

  lcd_scoreboard sb;
  bit idle_on;
  int stall_left;

  char_lcd_nibble_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .byte_value_i  (byte_value_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reg_select_o  (reg_select_o),
    .read_write_o  (read_write_o),
    .enable_o      (enable_o),
    .data_nibble_o (data_nibble_o),
    .hold_us_o     (hold_us_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Check each output transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    pin_evt_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.rs   = reg_select_o;
        got.rw   = read_write_o;
        got.en   = enable_o;
        got.nib  = data_nibble_o;
        got.hold = hold_us_o;
        got.last = last_o;
        sb.check_event(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [2:0] req, input logic [7:0] b,
                              input logic [1:0] row, input logic [6:0] col);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    byte_value_i <= b;
    row_i        <= row;
    column_i     <= col;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req, b, row, col);
  endtask

  // Drop valid and hold until every predicted event has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [9:0] vals [8]);
    for (int k = int'(RegFunctionSet); k <= int'(RegSpare); k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(k);
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(3'(k), vals[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    int pick;
    logic [1:0] row;
    logic [6:0] col;
    send_request(ReqInit, 8'($urandom), 2'($urandom), 7'($urandom));
    send_request(ReqClear, 8'($urandom), 2'($urandom), 7'($urandom));
    send_request(ReqHome, 8'($urandom), 2'($urandom), 7'($urandom));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      row  = 2'($urandom);
      col  = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
      if (pick < 3)       send_request(ReqInit, 8'($urandom), row, col);
      else if (pick < 25) send_request(ReqCmd, 8'($urandom), row, col);
      else if (pick < 55) send_request(ReqData, 8'($urandom), row, col);
      else if (pick < 80) send_request(ReqCur, 8'($urandom), row, col);
      else if (pick < 88) send_request(ReqClear, 8'($urandom), row, col);
      else if (pick < 96) send_request(ReqHome, 8'($urandom), row, col);
      else send_request(pick[0] ? ReqSpare6 : ReqSpare7, 8'($urandom), row, col);
    end
    drain();
  endtask

  initial begin
    logic [9:0] regs [8];
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    req_type_i   = '0;
    byte_value_i = '0;
    row_i        = '0;
    column_i     = '0;
    out_ready_i  = 1'b0;
    stall_left   = 0;
    idle_on      = 1'b1;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests on the reset codes and timings
    send_request(ReqInit, 8'h00, 2'd0, 7'd1);
    send_request(ReqCmd, 8'h00, 2'd3, 7'd127);
    send_request(ReqCmd, 8'hFF, 2'd0, 7'd0);
    send_request(ReqData, 8'h00, 2'd1, 7'd1);
    send_request(ReqData, 8'hFF, 2'd2, 7'd64);
    send_request(ReqData, 8'hA5, 2'd0, 7'd5);
    send_request(ReqCur, 8'hFF, RowFirst, 7'd1);
    send_request(ReqCur, 8'h00, RowFirst, 7'd64);
    send_request(ReqCur, 8'h5A, RowSecond, 7'd1);
    send_request(ReqCur, 8'hC3, RowSecond, 7'd127);
    send_request(ReqCur, 8'h00, RowFirst, 7'd0);
    send_request(ReqCur, 8'h00, 2'd0, 7'd5);
    send_request(ReqCur, 8'h00, 2'd3, 7'd5);
    send_request(ReqClear, 8'h3C, 2'd1, 7'd2);
    send_request(ReqHome, 8'hC3, 2'd2, 7'd3);
    send_request(ReqSpare6, 8'hFF, RowFirst, 7'd10);
    send_request(ReqSpare7, 8'h81, RowSecond, 7'd20);
    send_request(ReqCmd, 8'h5A, 2'd1, 7'd33);
    drain();

    // Largest register values, including bits above the code width
    foreach (regs[k]) regs[k] = 10'h3FF;
    program_regs(regs);
    run_phase(PhaseItems);

    foreach (regs[k]) regs[k] = 10'h000;
    program_regs(regs);
    run_phase(PhaseItems);

    foreach (regs[k]) regs[k] = 10'($urandom_range(0, 1023));
    regs[RegEnableHigh] = 10'($urandom_range(1, 1000));
    regs[RegEnableLow]  = 10'($urandom_range(1, 1000));
    program_regs(regs);
    run_phase(PhaseItems);

    // Final stretch at full rate on both sides
    idle_on = 1'b0;
    foreach (regs[k]) regs[k] = 10'($urandom_range(0, 1023));
    regs[RegEnableHigh] = 10'd1;
    regs[RegEnableLow]  = 10'd1000;
    program_regs(regs);
    run_phase(PhaseItems);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### char_lcd_nibble_sequencer.f
rtl/lcdns_pkg.sv
rtl/lcdns_front.sv
rtl/lcdns_queue.sv
rtl/lcdns_back.sv
rtl/char_lcd_nibble_sequencer.sv
tb/sv/char_lcd_nibble_sequencer_tb.sv
